>>> rtl/mf3_pkg.sv
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int WIN_N      = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eof;
        logic             emit;
    } t_meta;

endpackage

>>> rtl/window_median_filter_3x3_top.sv
// 3x3 median filter over a raster-ordered stream of 8-bit grey pixels.
// The pixel channel (i_pixel, i_valid, o_stall) takes one pixel per clock in
// raster order; a transfer happens on a clock edge with i_valid high and
// o_stall low. The result channel (o_median_value, o_centre_row,
// o_centre_col, o_end_of_frame, o_valid, i_stall) carries one transfer for
// each pixel that completes a 3x3 window, giving the median for the pixel one
// row up and one column left. Border pixels give no result.
// Each result passes the first-stage, window, sorted and output registers.
// Throughput is one pixel per cycle while o_stall is low; the line stores are read once and
// written once per pixel through one read port and one write port each.
// Frame size is to be written through i_cfg_* only while the block is idle;
// the block does not enforce this and the write is always taken. Out-of-range
// sizes are saturated to 3..1024 columns and 3..4096 rows.
// Reset clears the counters and sets a 640x480 frame; the line stores need
// no clearing. When i_stall is high the result holds, and pixels are still
// taken until the four internal stages are full.
module window_median_filter_3x3_top import mf3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic [PIX_W-1:0]      o_median_value,
    output logic [ROW_W-1:0]      o_centre_row,
    output logic [COL_W-1:0]      o_centre_col,
    output logic                  o_end_of_frame,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COL_W-1:0] r_wm1;
    logic [ROW_W-1:0] r_hm1;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_valid;
    t_pix             r_s1_px;
    logic [COL_W-1:0] r_s1_addr;
    t_meta            r_s1_meta;

    logic             r_s2_valid;
    t_win             r_win;
    t_meta            r_s2_meta;

    logic [COL_W-1:0] n_wm1;
    logic [ROW_W-1:0] n_hm1;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_meta            n_meta;
    t_win             n_win;

    logic [WIDTH_W-1:0]  cfg_w;
    logic [HEIGHT_W-1:0] cfg_h;
    logic                acc;
    logic                adv1;
    logic                en1;
    logic                en2;
    logic                med_ready;
    logic                last_col;
    logic                last_row;
    t_pix                top_px;
    t_pix                mid_px;
    t_pix                med_value;
    t_meta               med_meta;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_w = i_cfg_data[WIDTH_W-1:0];
        cfg_h = i_cfg_data[HEIGHT_W-1:0];
        if (cfg_w < WIDTH_W'(MIN_DIM)) begin
            n_wm1 = COL_W'(MIN_DIM - 1);
        end else if (cfg_w > WIDTH_W'(MAX_WIDTH)) begin
            n_wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_wm1 = COL_W'(cfg_w - WIDTH_W'(1));
        end
        if (cfg_h < HEIGHT_W'(MIN_DIM)) begin
            n_hm1 = ROW_W'(MIN_DIM - 1);
        end else if (cfg_h > HEIGHT_W'(MAX_HEIGHT)) begin
            n_hm1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_hm1 = ROW_W'(cfg_h - HEIGHT_W'(1));
        end
    end

    assign en2     = !r_s2_valid || med_ready;
    assign en1     = !r_s1_valid || en2;
    assign o_stall = !en1;
    assign acc     = i_valid && en1;
    assign adv1    = r_s1_valid && en2;

    always_comb begin
        last_col    = r_col >= r_wm1;
        last_row    = r_row >= r_hm1;
        n_col       = last_col ? '0 : r_col + COL_W'(1);
        n_row       = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
        n_meta.row  = r_row - ROW_W'(1);
        n_meta.col  = r_col - COL_W'(1);
        n_meta.eof  = (r_row == r_hm1) && (r_col == r_wm1);
        n_meta.emit = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    end

    mf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (adv1),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_px),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (top_px)
    );

    mf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .i_clk   (i_clk),
        .i_we    (adv1),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (mid_px)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[3*k]   = r_win[3*k+1];
            n_win[3*k+1] = r_win[3*k+2];
        end
        n_win[2] = top_px;
        n_win[5] = mid_px;
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1      <= COL_W'(639);
            r_hm1      <= ROW_W'(479);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        r_wm1 <= n_wm1;
                    end
                    REG_FRAME_HEIGHT: begin
                        r_hm1 <= n_hm1;
                    end
                    default: begin
                    end
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en1) begin
                r_s1_valid <= i_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (acc) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= r_col;
            r_s1_meta <= n_meta;
        end
        if (adv1) begin
            r_win     <= n_win;
            r_s2_meta <= r_s1_meta;
        end
    end

    mf3_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .i_win    (r_win),
        .i_meta   (r_s2_meta),
        .o_ready  (med_ready),
        .o_valid  (o_valid),
        .o_median (med_value),
        .o_meta   (med_meta),
        .i_stall  (i_stall)
    );

    assign o_median_value = med_value;
    assign o_centre_row   = med_meta.row;
    assign o_centre_col   = med_meta.col;
    assign o_end_of_frame = med_meta.eof;

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (r_col >= r_wm1)) |=> (r_col == '0))
        else $error("column counter did not wrap at the end of a row");

    a_eof_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_meta.eof) |-> r_s1_meta.emit)
        else $error("end of frame marked on a border pixel");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("pixel channel stalled with an empty first stage");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_valid)
        else $error("transferred pixel lost before the first stage");

endmodule

>>> rtl/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mf3_median.sv
module mf3_median import mf3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_win  i_win,
    input  t_meta i_meta,
    output logic  o_ready,
    output logic  o_valid,
    output t_pix  o_median,
    output t_meta o_meta,
    input  logic  i_stall
);

    function automatic logic [2:0][PIX_W-1:0] sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        t_pix mx;
        logic [2:0][PIX_W-1:0] s;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        mx = (hi < c) ? c : hi;
        s[2] = mx;
        s[0] = (lo < c) ? lo : c;
        s[1] = (hi < c) ? hi : ((lo < c) ? c : lo);
        return s;
    endfunction

    logic  r_s3_valid;
    t_win  r_s3_sorted;
    t_meta r_s3_meta;
    logic  r_out_valid;
    t_pix  r_out_median;
    t_meta r_out_meta;

    logic  en_out;
    logic  en3;
    t_win  n_sorted;
    t_pix  n_median;
    logic [2:0][PIX_W-1:0] lows;
    logic [2:0][PIX_W-1:0] mids;
    logic [2:0][PIX_W-1:0] highs;
    logic [2:0][PIX_W-1:0] col_lo;
    logic [2:0][PIX_W-1:0] col_mi;
    logic [2:0][PIX_W-1:0] col_hi;
    logic [2:0][PIX_W-1:0] last;

    assign en_out  = !r_out_valid || !i_stall;
    assign en3     = !r_s3_valid || en_out;
    assign o_ready = en3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            {n_sorted[3*k+2], n_sorted[3*k+1], n_sorted[3*k]} =
                sort3(i_win[3*k], i_win[3*k+1], i_win[3*k+2]);
        end
    end

    // After sorting each row, the median is the median of the largest low,
    // the median of the middles and the smallest high.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lows[k]  = r_s3_sorted[3*k];
            mids[k]  = r_s3_sorted[3*k+1];
            highs[k] = r_s3_sorted[3*k+2];
        end
        col_lo   = sort3(lows[0], lows[1], lows[2]);
        col_mi   = sort3(mids[0], mids[1], mids[2]);
        col_hi   = sort3(highs[0], highs[1], highs[2]);
        last     = sort3(col_lo[2], col_mi[1], col_hi[0]);
        n_median = last[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en3) begin
                r_s3_valid <= i_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s3_valid && r_s3_meta.emit;
            end
        end
        if (en3) begin
            r_s3_sorted <= n_sorted;
            r_s3_meta   <= i_meta;
        end
        if (en_out) begin
            r_out_median <= n_median;
            r_out_meta   <= r_s3_meta;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_median = r_out_median;
    assign o_meta   = r_out_meta;

endmodule

>>> tb/window_median_filter_3x3_top_tb.sv
module window_median_filter_3x3_top_tb;
    import mf3_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RAND_ITEMS    = 180;
    localparam int unsigned QUIET_ITEMS   = 60;
    localparam int unsigned LONG_HOLD     = 120;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct packed {
        t_pix             med;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eof;
    } t_median_result;

    typedef enum logic [0:0] {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        t_median_result        res;
    } t_plan_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      o_median_value;
    logic [ROW_W-1:0]      o_centre_row;
    logic [COL_W-1:0]      o_centre_col;
    logic                  o_end_of_frame;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    window_median_filter_3x3_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel        (i_pixel),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .o_median_value (o_median_value),
        .o_centre_row   (o_centre_row),
        .o_centre_col   (o_centre_col),
        .o_end_of_frame (o_end_of_frame),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [WIDTH_W-1:0]  cfg_width = WIDTH_W'(640);
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_W'(480);
    t_pix                prev2_row [MAX_WIDTH];
    t_pix                prev1_row [MAX_WIDTH];
    bit                  prev2_known [MAX_WIDTH];
    bit                  prev1_known [MAX_WIDTH];
    t_win                win_px = '0;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;

    t_median_result medians_due [$];
    t_plan_step     directed_plan [$];

    int unsigned tx_gap_rate = 0;
    int unsigned rx_gap_rate = 0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;
    int unsigned pixels_sent = 0;
    int unsigned medians_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned mid_frame_writes = 0;
    int unsigned rand_items = 0;
    t_median_result got_res;
    t_median_result want_res;

    function automatic int unsigned eff_width();
        if (cfg_width < MIN_DIM) return MIN_DIM;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < MIN_DIM) return MIN_DIM;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic int unsigned known_span();
        int unsigned n;
        n = 0;
        while (n < MAX_WIDTH && prev2_known[n] && prev1_known[n]) n++;
        return n;
    endfunction

    function automatic t_pix window_median(input t_win v);
        t_win s;
        t_pix tmp;
        int   i;
        int   j;
        s = v;
        for (i = 0; i < WIN_N - 1; i++) begin
            for (j = 0; j < WIN_N - 1 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    tmp = s[j];
                    s[j] = s[j+1];
                    s[j+1] = tmp;
                end
            end
        end
        return s[4];
    endfunction

    function automatic bit model_pixel(input t_pix px, output t_median_result res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          i;
        t_pix        up2;
        t_pix        up1;
        bit          emit;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        up2 = prev2_row[c];
        up1 = prev1_row[c];
        for (i = 0; i < 3; i++) begin
            win_px[i*3] = win_px[i*3+1];
            win_px[i*3+1] = win_px[i*3+2];
        end
        win_px[2] = up2;
        win_px[5] = up1;
        win_px[8] = px;
        prev2_row[c] = up1;
        prev2_known[c] = prev1_known[c];
        prev1_row[c] = px;
        prev1_known[c] = 1'b1;
        res = '0;
        emit = (r >= 2) && (c >= 2);
        if (emit) begin
            res.med = window_median(win_px);
            res.row = ROW_W'(r - 1);
            res.col = COL_W'(c - 1);
            res.eof = (r == h - 1) && (c == w - 1);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return emit;
    endfunction

    function automatic t_pix rand_pixel();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return t_pix'($urandom_range(0, 255));
        if (sel < 75) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return t_pix'($urandom_range(100, 103));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width_data(input int unsigned limit);
        int unsigned           top;
        int unsigned           sel;
        logic [CFG_DATA_W-1:0] d;
        top = (limit < 12) ? limit : 12;
        sel = $urandom_range(0, 99);
        d = CFG_DATA_W'($urandom_range(MIN_DIM, top));
        if (sel < 15) begin
            d = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
        end else if (sel < 30) begin
            d[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W-WIDTH_W)'($urandom_range(1, 3));
        end
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height_data();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
        return CFG_DATA_W'($urandom_range(MIN_DIM, 8));
    endfunction

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return 30;
        endcase
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_plan_step s;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.data = data;
        s.typed = 1'b0;
        s.res = '0;
        directed_plan.push_back(s);
    endfunction

    function automatic void add_pix(input t_pix px, input bit typed, input t_pix med,
                                    input int unsigned row, input int unsigned col,
                                    input bit eof);
        t_plan_step s;
        s.kind = STEP_PIX;
        s.idx = '0;
        s.data = CFG_DATA_W'(px);
        s.typed = typed;
        s.res.med = med;
        s.res.row = ROW_W'(row);
        s.res.col = COL_W'(col);
        s.res.eof = eof;
        directed_plan.push_back(s);
    endfunction

    task automatic push_pixel(input t_pix px, input bit typed, input t_median_result typed_res);
        t_median_result res;
        if ($urandom_range(0, 99) < tx_gap_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_pixel <= px;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
        if (model_pixel(px, res)) medians_due.push_back(typed ? typed_res : res);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = data[WIDTH_W-1:0];
        else cfg_height = data[HEIGHT_W-1:0];
        cfg_writes++;
        if (col_pos != 0 || row_pos != 0) mid_frame_writes++;
    endtask

    task automatic run_to_frame_end();
        do push_pixel(rand_pixel(), 1'b0, '0);
        while (col_pos != 0 || row_pos != 0);
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : result_stall
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_gap_rate) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_res.med = o_median_value;
            got_res.row = o_centre_row;
            got_res.col = o_centre_col;
            got_res.eof = o_end_of_frame;
            if (got_res.eof) frames_seen++;
            if (medians_due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Unexpected transfer: median %0d row %0d col %0d eof %0d",
                             got_res.med, got_res.row, got_res.col, got_res.eof);
            end else begin
                want_res = medians_due.pop_front();
                medians_checked++;
                if (got_res !== want_res) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("Mismatch: expected median %0d row %0d col %0d eof %0d,",
                                 want_res.med, want_res.row, want_res.col, want_res.eof,
                                 " got median %0d row %0d col %0d eof %0d",
                                 got_res.med, got_res.row, got_res.col, got_res.eof);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned span;
        int          i;
        bit          quiet;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // One full row at the reset width of 640 leaves the counters at the start of row one.
        repeat (640) add_pix(rand_pixel(), 1'b0, '0, 0, 0, 1'b0);
        // The size drops to 3x3 mid-frame, and two short rows close the frame.
        add_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        add_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        repeat (6) add_pix(rand_pixel(), 1'b0, '0, 0, 0, 1'b0);
        for (i = 0; i < 9; i++) add_pix(i[0] ? 8'h00 : 8'hFF, i == 8, 8'hFF, 1, 1, 1'b1);
        add_cfg(REG_FRAME_WIDTH, 13'h1802);
        add_cfg(REG_FRAME_HEIGHT, 13'h0000);
        for (i = 0; i < 9; i++) add_pix(i[0] ? 8'hFF : 8'h00, i == 8, 8'h00, 1, 1, 1'b1);
        // Sizes above both limits, cut short by mid-frame writes.
        add_cfg(REG_FRAME_WIDTH, 13'h07FF);
        add_cfg(REG_FRAME_HEIGHT, 13'h1FFF);
        repeat (20) add_pix(rand_pixel(), 1'b0, '0, 0, 0, 1'b0);
        add_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        repeat (16) add_pix(rand_pixel(), 1'b0, '0, 0, 0, 1'b0);
        add_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        repeat (3) add_pix(rand_pixel(), 1'b0, '0, 0, 0, 1'b0);

        tx_gap_rate = 8;
        rx_gap_rate = 8;
        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == STEP_CFG)
                write_reg(directed_plan[k].idx, directed_plan[k].data);
            else
                push_pixel(directed_plan[k].data[PIX_W-1:0], directed_plan[k].typed,
                           directed_plan[k].res);
        end

        tx_gap_rate = 0;
        rx_gap_rate = 0;
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(8));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(8));
        long_hold_req = 1'b1;
        run_to_frame_end();

        while (rand_items < RAND_ITEMS) begin
            quiet = (rand_items + QUIET_ITEMS >= RAND_ITEMS);
            if (quiet) begin
                tx_gap_rate = 0;
                rx_gap_rate = 0;
            end else begin
                tx_gap_rate = pick_rate();
                rx_gap_rate = pick_rate();
                if (col_pos == 0 && row_pos == 0) begin
                    if ($urandom_range(0, 3) != 0)
                        write_reg(REG_FRAME_WIDTH, pick_width_data(12));
                    if ($urandom_range(0, 3) != 0)
                        write_reg(REG_FRAME_HEIGHT, pick_height_data());
                end else if ($urandom_range(0, 2) == 0) begin
                    // Mid-frame width changes stay within columns both line stores hold.
                    span = known_span();
                    if ($urandom_range(0, 1) == 1 && eff_width() <= span)
                        write_reg(REG_FRAME_WIDTH, pick_width_data(span));
                    else
                        write_reg(REG_FRAME_HEIGHT, pick_height_data());
                end
            end
            if ($urandom_range(0, 9) < 7) begin
                do begin
                    push_pixel(rand_pixel(), 1'b0, '0);
                    rand_items++;
                end while (col_pos != 0 || row_pos != 0);
            end else begin
                repeat ($urandom_range(1, 40)) begin
                    push_pixel(rand_pixel(), 1'b0, '0);
                    rand_items++;
                end
            end
        end

        settle();
        $display("Run covered %0d pixels, %0d checked medians and %0d frame ends in %0d cycles.",
                 pixels_sent, medians_checked, frames_seen, cycle_count);
        $display("Frame size was written %0d times, %0d of them mid-frame, some beyond limits.",
                 cfg_writes, mid_frame_writes);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/mf3_median.sv
rtl/window_median_filter_3x3_top.sv
tb/window_median_filter_3x3_top_tb.sv
